/* design/assert_macros.svh */
// Assertion macros used by two_button_press_classifier.
// Depends on nothing; simulation builds see the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* design/tbpc_pkg.sv */
// Types and constants for the two-button press classifier.
// No dependencies; imported by two_button_press_classifier.
package tbpc_pkg;

    localparam int unsigned TICK_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd5;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd300;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_BOTH_LONG    = 3'd1,
        EV_ID_LONG_END  = 3'd2,
        EV_ID_SHORT     = 3'd3,
        EV_EXEC_PRESS   = 3'd4,
        EV_EXEC_RELEASE = 3'd5
    } event_t;

    typedef struct packed {
        logic id_pin_level;
        logic exec_pin_level;
    } in_item_t;

    typedef struct packed {
        event_t              event_res;
        logic [TICK_W-1:0]   exec_duration;
        logic                id_debounced;
        logic                exec_debounced;
    } out_item_t;

endpackage

/* design/two_button_press_classifier.sv */
// Two-button debounce and press classifier, top level.
// Depends on tbpc_pkg and assert_macros.svh.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    in_item_t  (raw active-low pin levels)
//  m_        out        m_valid/m_ready    out_item_t (event, duration, debounced states)
//  APB       in         psel/penable       debounce_ticks @0x0, long_press_ticks @0x4
//
// One tick per cycle while the result side is not stalled: a sample waits in the input
// register, then the whole per-tick update (two debounce compares, press timers,
// classification) runs in one combinational pass into the result register, from
// which the result is offered.
// Stalls on m_ready hold the result register; the input register still refills
// as soon as the result register frees. Synchronous active-low reset returns all
// tick state, the configuration and both valid flags to reset; data registers are not reset.
`include "assert_macros.svh"

module two_button_press_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tbpc_pkg::in_item_t            s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tbpc_pkg::out_item_t           m_payload,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbpc_pkg::APB_AW-1:0]   paddr,
    input  logic [tbpc_pkg::APB_DW-1:0]   pwdata,
    output logic [tbpc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import tbpc_pkg::*;

    // Configuration
    logic [CFG_W-1:0] debounce_reg, long_press_reg;
    reg_idx_t         cfg_idx;

    // Pipeline registers
    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       advance;

    // Tick state
    logic [TICK_W-1:0] tick_reg;
    logic              id_stable_reg, exec_stable_reg;
    logic [TICK_W-1:0] id_chg_time_reg, exec_chg_time_reg;
    logic [TICK_W-1:0] id_start_reg, exec_start_reg, both_start_reg;
    logic              id_active_reg, exec_active_reg, both_active_reg, lockout_reg;
    logic [TICK_W-1:0] duration_reg;

    logic              id_stable_next, exec_stable_next;
    logic [TICK_W-1:0] id_chg_time_next, exec_chg_time_next;
    logic [TICK_W-1:0] id_start_next, exec_start_next, both_start_next;
    logic              id_active_next, exec_active_next, both_active_next, lockout_next;
    logic [TICK_W-1:0] duration_next;
    event_t            ev_next;

    logic              id_now, exec_now, both;
    logic [TICK_W-1:0] now, db_ext, lp_ext;

    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            REG_DEBOUNCE:   prdata = {{(APB_DW-CFG_W){1'b0}}, debounce_reg};
            REG_LONG_PRESS: prdata = {{(APB_DW-CFG_W){1'b0}}, long_press_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_DEBOUNCE:   debounce_reg   <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_payload = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready)
                in_valid_reg <= s_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_item_reg <= s_payload;
        if (advance)
            out_item_reg <= '{event_res: ev_next, exec_duration: duration_next,
                               id_debounced: id_stable_next,
                               exec_debounced: exec_stable_next};
    end

    // Per-tick update
    always_comb begin
        now    = tick_reg;
        db_ext = {{(TICK_W-CFG_W){1'b0}}, debounce_reg};
        lp_ext = {{(TICK_W-CFG_W){1'b0}}, long_press_reg};
        id_now   = !in_item_reg.id_pin_level;
        exec_now = !in_item_reg.exec_pin_level;

        id_stable_next     = id_stable_reg;
        id_chg_time_next   = id_chg_time_reg;
        exec_stable_next   = exec_stable_reg;
        exec_chg_time_next = exec_chg_time_reg;
        id_start_next      = id_start_reg;
        exec_start_next    = exec_start_reg;
        both_start_next    = both_start_reg;
        id_active_next     = id_active_reg;
        exec_active_next   = exec_active_reg;
        both_active_next   = both_active_reg;
        lockout_next       = lockout_reg;
        duration_next      = duration_reg;
        ev_next            = EV_NONE;

        if (id_now != id_stable_reg && (now - id_chg_time_reg) > db_ext) begin
            id_stable_next   = id_now;
            id_chg_time_next = now;
        end
        if (exec_now != exec_stable_reg && (now - exec_chg_time_reg) > db_ext) begin
            exec_stable_next   = exec_now;
            exec_chg_time_next = now;
        end
        both = id_stable_next && exec_stable_next;

        if (lockout_reg) begin
            lockout_next = both;
        end else begin
            if (both) begin
                if (!both_active_reg) begin
                    both_start_next  = now;
                    both_active_next = 1'b1;
                end
                id_active_next   = 1'b0;
                exec_active_next = 1'b0;
            end

            if (both_active_next && both && (now - both_start_next) >= lp_ext) begin
                both_active_next = 1'b0;
                lockout_next     = 1'b1;
                ev_next          = EV_BOTH_LONG;
            end else begin
                if (both_active_next && !both)
                    both_active_next = 1'b0;

                if (id_stable_next && !exec_stable_next && !id_active_next) begin
                    id_start_next  = now;
                    id_active_next = 1'b1;
                end else if (!id_stable_next && id_active_next) begin
                    ev_next = ((now - id_start_reg) >= lp_ext) ? EV_ID_LONG_END : EV_ID_SHORT;
                    id_active_next = 1'b0;
                end

                if (exec_stable_next && !id_stable_next && !exec_active_next) begin
                    exec_start_next  = now;
                    exec_active_next = 1'b1;
                    ev_next          = EV_EXEC_PRESS;
                end else if (!exec_stable_next && exec_active_next) begin
                    duration_next    = now - exec_start_reg;
                    exec_active_next = 1'b0;
                    ev_next          = EV_EXEC_RELEASE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg          <= '0;
            id_stable_reg     <= 1'b0;
            exec_stable_reg   <= 1'b0;
            id_chg_time_reg   <= '0;
            exec_chg_time_reg <= '0;
            id_start_reg      <= '0;
            exec_start_reg    <= '0;
            both_start_reg    <= '0;
            id_active_reg     <= 1'b0;
            exec_active_reg   <= 1'b0;
            both_active_reg   <= 1'b0;
            lockout_reg       <= 1'b0;
            duration_reg      <= '0;
        end else if (advance) begin
            tick_reg          <= tick_reg + 1'b1;
            id_stable_reg     <= id_stable_next;
            exec_stable_reg   <= exec_stable_next;
            id_chg_time_reg   <= id_chg_time_next;
            exec_chg_time_reg <= exec_chg_time_next;
            id_start_reg      <= id_start_next;
            exec_start_reg    <= exec_start_next;
            both_start_reg    <= both_start_next;
            id_active_reg     <= id_active_next;
            exec_active_reg   <= exec_active_next;
            both_active_reg   <= both_active_next;
            lockout_reg       <= lockout_next;
            duration_reg      <= duration_next;
        end
    end

    // Checks
    `ASSERT_ALWAYS(a_lock_excl, aclk, aresetn, !(lockout_reg && both_active_reg),
                   "lockout with both timer running")
    `ASSERT_ALWAYS(a_press_excl, aclk, aresetn, !(id_active_reg && exec_active_reg),
                   "id and exec presses active together")
    `ASSERT_NEXT(a_tick_step, aclk, aresetn, advance, tick_reg == $past(tick_reg) + 1'b1,
                 "tick counter did not step")
    `ASSERT_IMPLY(a_rel_up, aclk, aresetn,
                  out_valid_reg && out_item_reg.event_res == EV_EXEC_RELEASE,
                  !out_item_reg.exec_debounced, "exec release while exec pressed")
    `ASSERT_IMPLY(a_lock_both, aclk, aresetn, lockout_reg, id_stable_reg && exec_stable_reg,
                  "lockout without both buttons held")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for two_button_press_classifier: ticks in, one result per tick out.
// Needs tbpc_pkg and the RTL; the expected results come from a tick-level model kept below.
module testbench;
    import tbpc_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int MAX_PRINT      = 60;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_payload = '1;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_payload;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    two_button_press_classifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 aclk = ~aclk;

    // Register copies and tick-level press state
    logic [CFG_W-1:0]  cfg_debounce  = DEBOUNCE_RST;
    logic [CFG_W-1:0]  cfg_long      = LONG_PRESS_RST;
    logic [TICK_W-1:0] p_ticks       = '0;
    logic              p_id_db       = 1'b0;
    logic              p_ex_db       = 1'b0;
    logic [TICK_W-1:0] p_id_chg_t    = '0;
    logic [TICK_W-1:0] p_ex_chg_t    = '0;
    logic [TICK_W-1:0] p_id_start    = '0;
    logic              p_id_held     = 1'b0;
    logic [TICK_W-1:0] p_ex_start    = '0;
    logic              p_ex_held     = 1'b0;
    logic [TICK_W-1:0] p_both_start  = '0;
    logic              p_both_held   = 1'b0;
    logic              p_locked      = 1'b0;
    logic [TICK_W-1:0] p_ex_dur      = '0;

    out_item_t expected_results[$];
    out_item_t want;
    int        errors      = 0;
    int        ticks_sent  = 0;
    int        cycles      = 0;
    int        ev_seen[8]  = '{default: 0};
    int        settings_run = 1;
    bit        gaps_on     = 1'b1;
    bit        rx_hold_req = 1'b0;

    function automatic out_item_t classify_tick(in_item_t pins);
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] held_for;
        logic              id_dn;
        logic              ex_dn;
        logic              both;
        logic              fired;
        event_t            ev;
        out_item_t         res;
        now   = p_ticks;
        id_dn = ~pins.id_pin_level;
        ex_dn = ~pins.exec_pin_level;
        ev    = EV_NONE;
        fired = 1'b0;
        p_ticks = p_ticks + 1;

        if (id_dn != p_id_db && (now - p_id_chg_t) > {16'd0, cfg_debounce}) begin
            p_id_db    = id_dn;
            p_id_chg_t = now;
        end
        if (ex_dn != p_ex_db && (now - p_ex_chg_t) > {16'd0, cfg_debounce}) begin
            p_ex_db    = ex_dn;
            p_ex_chg_t = now;
        end
        both = p_id_db & p_ex_db;

        if (p_locked) begin
            // lockout swallows everything until one button lets go
            if (!both) p_locked = 1'b0;
        end else begin
            if (both) begin
                if (!p_both_held) begin
                    p_both_start = now;
                    p_both_held  = 1'b1;
                end
                p_id_held = 1'b0;
                p_ex_held = 1'b0;
            end
            if (p_both_held) begin
                held_for = now - p_both_start;
                if (!both) begin
                    p_both_held = 1'b0;
                end else if (held_for >= {16'd0, cfg_long}) begin
                    p_both_held = 1'b0;
                    p_locked    = 1'b1;
                    ev          = EV_BOTH_LONG;
                    fired       = 1'b1;
                end
            end
            if (!fired) begin
                if (p_id_db && !p_ex_db && !p_id_held) begin
                    p_id_start = now;
                    p_id_held  = 1'b1;
                end else if (!p_id_db && p_id_held) begin
                    held_for  = now - p_id_start;
                    ev        = (held_for >= {16'd0, cfg_long}) ? EV_ID_LONG_END : EV_ID_SHORT;
                    p_id_held = 1'b0;
                end
                if (p_ex_db && !p_id_db && !p_ex_held) begin
                    p_ex_start = now;
                    p_ex_held  = 1'b1;
                    ev         = EV_EXEC_PRESS;
                end else if (!p_ex_db && p_ex_held) begin
                    p_ex_dur  = now - p_ex_start;
                    p_ex_held = 1'b0;
                    ev        = EV_EXEC_RELEASE;
                end
            end
        end

        res.event_res      = ev;
        res.exec_duration  = p_ex_dur;
        res.id_debounced   = p_id_db;
        res.exec_debounced = p_ex_db;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            // keep the log readable on a badly broken build
            if (errors <= MAX_PRINT)
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, got_v);
        end
    endfunction

    // Accepted ticks feed the model; each returned transaction is checked in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(classify_tick(s_payload));
                ticks_sent++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_PRINT)
                        $display("%0t: result with no tick outstanding", $time);
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res", want.event_res, m_payload.event_res);
                    check_field("exec_duration", want.exec_duration, m_payload.exec_duration);
                    check_field("id_debounced", want.id_debounced, m_payload.id_debounced);
                    check_field("exec_debounced", want.exec_debounced,
                                m_payload.exec_debounced);
                    if (!$isunknown(m_payload.event_res)) ev_seen[m_payload.event_res]++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold on request
    initial begin : result_sink
        int stall;
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            stall = gaps_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_tick(input logic id_lvl, input logic ex_lvl);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid                  <= 1'b1;
        s_payload.id_pin_level   <= id_lvl;
        s_payload.exec_pin_level <= ex_lvl;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_levels(input logic id_lvl, input logic ex_lvl, input int count);
        repeat (count) send_tick(id_lvl, ex_lvl);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_DEBOUNCE) cfg_debounce = val;
        else cfg_long = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_reg(input reg_idx_t idx);
        logic [CFG_W-1:0] exp_v;
        exp_v   = (idx == REG_DEBOUNCE) ? cfg_debounce : cfg_long;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field(idx == REG_DEBOUNCE ? "debounce readback" : "long press readback",
                    {16'd0, exp_v}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng);
        drain_results();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        read_reg(REG_DEBOUNCE);
        read_reg(REG_LONG_PRESS);
        settings_run++;
    endtask

    // Press episodes: a target level pair held for a while, bounce on the edge,
    // with some plain noise mixed in
    task automatic run_presses(input int n_ticks);
        int sent;
        int hold;
        int bounce;
        int pick;
        int cap;
        int extra;
        sent  = 0;
        cap   = (cfg_long > 16'd20) ? 40 : 2 * int'(cfg_long) + 6;
        extra = (cfg_debounce > 16'd8) ? 8 : int'(cfg_debounce);
        while (sent < n_ticks) begin
            if ($urandom_range(0, 9) < 8) begin
                pick   = $urandom_range(0, 3);
                hold   = $urandom_range(1, cap + extra);
                bounce = (cfg_debounce <= 16'd8) ? $urandom_range(0, int'(cfg_debounce)) : 0;
                for (int i = 0; i < hold; i++) begin
                    if (i < bounce)
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    else
                        send_tick(~pick[1], ~pick[0]);
                end
                sent += hold;
            end else begin
                hold = $urandom_range(1, 5);
                repeat (hold) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent += hold;
            end
        end
    endtask

    // Reset values, and a press right after reset that the debounce must hold off
    task automatic test_early_ticks();
        read_reg(REG_DEBOUNCE);
        read_reg(REG_LONG_PRESS);
        send_levels(1'b0, 1'b1, 8);
    endtask

    task automatic test_directed_events();
        set_config(16'd0, 16'd3);
        send_levels(1'b1, 1'b1, 1);
        // id short, then id long
        send_levels(1'b0, 1'b1, 1);
        send_levels(1'b1, 1'b1, 1);
        send_levels(1'b0, 1'b1, 4);
        send_levels(1'b1, 1'b1, 1);
        // exec press and release
        send_levels(1'b1, 1'b0, 2);
        send_levels(1'b1, 1'b1, 1);
        // both long, lockout, release
        send_levels(1'b0, 1'b0, 5);
        send_levels(1'b1, 1'b1, 2);
        // exec joins a held id: short both hold, no event
        send_levels(1'b0, 1'b1, 1);
        send_levels(1'b0, 1'b0, 2);
        send_levels(1'b1, 1'b1, 1);
    endtask

    // With a zero long-press time every hold is long
    task automatic test_zero_long_press();
        set_config(16'd1, 16'd0);
        send_levels(1'b0, 1'b1, 1);
        send_levels(1'b1, 1'b1, 3);
        send_levels(1'b0, 1'b0, 3);
        send_levels(1'b1, 1'b1, 3);
        run_presses(50);
    endtask

    task automatic test_extreme_settings();
        set_config(16'hFFFF, 16'hFFFF);
        run_presses(40);
        set_config(16'd0, 16'hFFFF);
        run_presses(40);
        set_config(16'hFFFF, 16'd1);
        run_presses(30);
        set_config(16'd0, 16'd1);
        run_presses(60);
    endtask

    task automatic test_random_presses();
        for (int p = 0; p < 6; p++) begin
            set_config((p == 0) ? 16'd0 : CFG_W'($urandom_range(0, 5)),
                       CFG_W'($urandom_range(1, 24)));
            gaps_on = (p != 2);
            run_presses(50);
        end
        gaps_on = 1'b1;
    endtask

    // Result side holds off while ticks keep coming, so the input stalls
    task automatic test_receiver_backpressure();
        set_config(16'd2, 16'd6);
        gaps_on     = 1'b0;
        rx_hold_req = 1'b1;
        run_presses(40);
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        set_config(16'd1, 16'd8);
        run_presses(25);
        drain_results();
        run_presses(25);
    endtask

    initial begin : main
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_early_ticks();
        test_directed_events();
        test_zero_long_press();
        test_extreme_settings();
        test_random_presses();
        test_receiver_backpressure();
        test_pause_until_drained();
        drain_results();
        repeat (8) @(posedge aclk);
        $display("summary: %0d ticks over %0d register settings, %0d errors", ticks_sent,
                 settings_run, errors);
        $display("summary: events none %0d, both-long %0d, id-long-end %0d, %s %0d/%0d/%0d",
                 ev_seen[EV_NONE], ev_seen[EV_BOTH_LONG], ev_seen[EV_ID_LONG_END],
                 "id-short, exec press/release", ev_seen[EV_ID_SHORT],
                 ev_seen[EV_EXEC_PRESS], ev_seen[EV_EXEC_RELEASE]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
